### rtl/pnm_pkg.sv
package pnm_pkg;

   localparam int LINE_LIMIT = 255;
   localparam int VALUE_BITS = 16;
   localparam int OUT_BITS = 16;
   localparam int LINE_BITS = $clog2(LINE_LIMIT + 1);

   // Both queues use this depth; it must be a power of two so the pointers wrap.
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_VTAB = 8'h0B;
   localparam logic [7:0] CHAR_FEED = 8'h0C;
   localparam logic [7:0] CHAR_RETURN = 8'h0D;

   localparam logic [2:0] STATUS_PARSING = 3'd0;
   localparam logic [2:0] STATUS_DONE = 3'd1;
   localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
   localparam logic [2:0] STATUS_BAD_SIZE = 3'd3;
   localparam logic [2:0] STATUS_BAD_MAX = 3'd4;
   localparam logic [2:0] STATUS_TOO_LONG = 3'd5;
   localparam logic [2:0] STATUS_EARLY_END = 3'd6;

   typedef enum logic [3:0] {
      PHASE_MAGIC = 4'b0001,
      PHASE_SIZE  = 4'b0010,
      PHASE_MAX   = 4'b0100,
      PHASE_DONE  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_P     = 2'd1,
      CLASS_DIGIT = 2'd2,
      CLASS_OTHER = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      STEP_FIRST  = 3'd0,
      STEP_GAP    = 3'd1,
      STEP_SECOND = 3'd2,
      STEP_TAIL   = 3'd3,
      STEP_FAIL   = 3'd4
   } step_type;

   typedef struct packed {
      logic       start_new;
      logic       input_ended;
      logic       is_newline;
      logic       is_hash;
      logic       is_p;
      logic       is_digit;
      logic       is_blank;
      logic [3:0] digit;
   } item_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [OUT_BITS-1:0] image_width;
      logic [OUT_BITS-1:0] image_height;
      logic [OUT_BITS-1:0] max_value;
   } result_type;

   // acc * 10 + d, held at the all-ones value on overflow.
   function automatic logic [VALUE_BITS-1:0] add_digit(input logic [VALUE_BITS-1:0] acc,
                                                      input logic [3:0] d);
      logic [VALUE_BITS+3:0] wide;
      logic [VALUE_BITS+3:0] sum;
      wide = {4'd0, acc};
      sum = (wide << 3) + (wide << 1) + {{VALUE_BITS{1'b0}}, d};
      if (sum[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
         return {VALUE_BITS{1'b1}};
      end
      return sum[VALUE_BITS-1:0];
   endfunction

endpackage

### rtl/pnm_front.sv
module pnm_front (
   input  logic [7:0]        data_byte,
   input  logic              input_ended,
   input  logic              start_new,
   output pnm_pkg::item_type item
);

   logic is_digit;

   assign is_digit = (data_byte >= pnm_pkg::CHAR_ZERO) && (data_byte <= pnm_pkg::CHAR_NINE);

   always_comb begin
      item.start_new = start_new;
      item.input_ended = input_ended;
      item.is_newline = (data_byte == pnm_pkg::CHAR_NEWLINE);
      item.is_hash = (data_byte == pnm_pkg::CHAR_HASH);
      item.is_p = (data_byte == pnm_pkg::CHAR_P);
      item.is_digit = is_digit;
      item.is_blank = (data_byte == pnm_pkg::CHAR_SPACE) || (data_byte == pnm_pkg::CHAR_TAB) ||
                      (data_byte == pnm_pkg::CHAR_VTAB) || (data_byte == pnm_pkg::CHAR_FEED) ||
                      (data_byte == pnm_pkg::CHAR_RETURN);
      item.digit = is_digit ? data_byte[3:0] : 4'd0;
   end

endmodule

### rtl/pnm_queue.sv
module pnm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  pnm_pkg::item_type wr_item,
   output logic              full,
   input  logic              rd_en,
   output pnm_pkg::item_type rd_item,
   output logic              empty
);

   pnm_pkg::item_type entry_ff [pnm_pkg::QUEUE_DEPTH];
   logic [pnm_pkg::PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pnm_pkg::PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pnm_pkg::COUNT_BITS-1:0] count_ff, count_in;

   assign full = (count_ff == pnm_pkg::COUNT_BITS'(pnm_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rd_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + pnm_pkg::PTR_BITS'(1);
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + pnm_pkg::PTR_BITS'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + pnm_pkg::COUNT_BITS'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - pnm_pkg::COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### rtl/pnm_back.sv
module pnm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  pnm_pkg::item_type   item,
   output logic                item_take,
   input  logic                out_pop,
   output logic                out_empty,
   output pnm_pkg::result_type out_result
);

   pnm_pkg::phase_type phase_ff, phase_in;
   pnm_pkg::class_type class_ff, class_in;
   pnm_pkg::step_type step_ff, step_in;
   logic comment_ff, comment_in;
   logic [pnm_pkg::LINE_BITS-1:0] line_ff, line_in;
   logic [pnm_pkg::VALUE_BITS-1:0] width_ff, width_in;
   logic [pnm_pkg::VALUE_BITS-1:0] height_ff, height_in;
   logic [pnm_pkg::VALUE_BITS-1:0] maxval_ff, maxval_in;
   logic [2:0] status_ff, status_in;

   pnm_pkg::result_type result_ff [pnm_pkg::QUEUE_DEPTH];
   pnm_pkg::result_type new_result;
   logic [pnm_pkg::PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pnm_pkg::COUNT_BITS-1:0] count_ff;
   logic do_pop;

   assign item_take = item_valid && (count_ff != pnm_pkg::COUNT_BITS'(pnm_pkg::QUEUE_DEPTH));
   assign out_empty = (count_ff == '0);
   assign do_pop = out_pop && !out_empty;
   assign out_result = result_ff[rd_ptr_ff];

   always_comb begin
      phase_in = phase_ff;
      class_in = class_ff;
      step_in = step_ff;
      comment_in = comment_ff;
      line_in = line_ff;
      width_in = width_ff;
      height_in = height_ff;
      maxval_in = maxval_ff;
      status_in = status_ff;

      if (item.start_new) begin
         phase_in = pnm_pkg::PHASE_MAGIC;
         class_in = pnm_pkg::CLASS_NONE;
         step_in = pnm_pkg::STEP_FIRST;
         comment_in = 1'b0;
         line_in = '0;
         width_in = '0;
         height_in = '0;
         maxval_in = '0;
         status_in = pnm_pkg::STATUS_PARSING;
      end

      if (status_in == pnm_pkg::STATUS_PARSING) begin
         if (item.input_ended) begin
            status_in = pnm_pkg::STATUS_EARLY_END;
         end else if (item.is_newline) begin
            // A line is judged only when its newline arrives; empty lines are skipped.
            if (class_in != pnm_pkg::CLASS_NONE) begin
               case (phase_in)
                  pnm_pkg::PHASE_MAGIC: begin
                     if (class_in == pnm_pkg::CLASS_P) begin
                        phase_in = pnm_pkg::PHASE_SIZE;
                     end else begin
                        status_in = pnm_pkg::STATUS_BAD_MAGIC;
                     end
                  end
                  pnm_pkg::PHASE_SIZE: begin
                     if (class_in == pnm_pkg::CLASS_DIGIT &&
                         (step_in == pnm_pkg::STEP_SECOND || step_in == pnm_pkg::STEP_TAIL)) begin
                        phase_in = pnm_pkg::PHASE_MAX;
                     end else begin
                        status_in = pnm_pkg::STATUS_BAD_SIZE;
                     end
                  end
                  pnm_pkg::PHASE_MAX: begin
                     if (class_in == pnm_pkg::CLASS_DIGIT) begin
                        phase_in = pnm_pkg::PHASE_DONE;
                        status_in = pnm_pkg::STATUS_DONE;
                     end else begin
                        status_in = pnm_pkg::STATUS_BAD_MAX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            comment_in = 1'b0;
            line_in = '0;
            class_in = pnm_pkg::CLASS_NONE;
            step_in = pnm_pkg::STEP_FIRST;
         end else if (item.is_hash) begin
            comment_in = 1'b1;
         end else if (!comment_in) begin
            if (line_in == '0) begin
               if (item.is_p) begin
                  class_in = pnm_pkg::CLASS_P;
               end else if (item.is_digit) begin
                  class_in = pnm_pkg::CLASS_DIGIT;
               end else begin
                  class_in = pnm_pkg::CLASS_OTHER;
               end
               step_in = pnm_pkg::STEP_FIRST;
               if (item.is_digit && phase_in == pnm_pkg::PHASE_SIZE) begin
                  width_in = '0;
                  height_in = '0;
               end
               if (item.is_digit && phase_in == pnm_pkg::PHASE_MAX) begin
                  maxval_in = '0;
               end
            end

            if (class_in == pnm_pkg::CLASS_DIGIT) begin
               if (phase_in == pnm_pkg::PHASE_SIZE) begin
                  case (step_in)
                     pnm_pkg::STEP_FIRST: begin
                        if (item.is_digit) begin
                           width_in = pnm_pkg::add_digit(width_in, item.digit);
                        end else if (item.is_blank) begin
                           step_in = pnm_pkg::STEP_GAP;
                        end else begin
                           step_in = pnm_pkg::STEP_FAIL;
                        end
                     end
                     pnm_pkg::STEP_GAP: begin
                        if (item.is_digit) begin
                           height_in = pnm_pkg::add_digit(height_in, item.digit);
                           step_in = pnm_pkg::STEP_SECOND;
                        end else if (!item.is_blank) begin
                           step_in = pnm_pkg::STEP_FAIL;
                        end
                     end
                     pnm_pkg::STEP_SECOND: begin
                        if (item.is_digit) begin
                           height_in = pnm_pkg::add_digit(height_in, item.digit);
                        end else begin
                           step_in = pnm_pkg::STEP_TAIL;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else if (phase_in == pnm_pkg::PHASE_MAX) begin
                  if (step_in == pnm_pkg::STEP_FIRST) begin
                     if (item.is_digit) begin
                        maxval_in = pnm_pkg::add_digit(maxval_in, item.digit);
                     end else begin
                        step_in = pnm_pkg::STEP_TAIL;
                     end
                  end
               end
            end

            line_in = line_in + pnm_pkg::LINE_BITS'(1);
            if (line_in >= pnm_pkg::LINE_BITS'(pnm_pkg::LINE_LIMIT)) begin
               status_in = pnm_pkg::STATUS_TOO_LONG;
            end
         end
      end

      new_result.status = status_in;
      new_result.image_width = pnm_pkg::OUT_BITS'(width_in);
      new_result.image_height = pnm_pkg::OUT_BITS'(height_in);
      new_result.max_value = pnm_pkg::OUT_BITS'(maxval_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pnm_pkg::PHASE_MAGIC;
         class_ff <= pnm_pkg::CLASS_NONE;
         step_ff <= pnm_pkg::STEP_FIRST;
         comment_ff <= 1'b0;
         line_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
         maxval_ff <= '0;
         status_ff <= pnm_pkg::STATUS_PARSING;
      end else if (item_take) begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         step_ff <= step_in;
         comment_ff <= comment_in;
         line_ff <= line_in;
         width_ff <= width_in;
         height_ff <= height_in;
         maxval_ff <= maxval_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (item_take) begin
            wr_ptr_ff <= wr_ptr_ff + pnm_pkg::PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + pnm_pkg::PTR_BITS'(1);
         end
         if (item_take && !do_pop) begin
            count_ff <= count_ff + pnm_pkg::COUNT_BITS'(1);
         end else if (do_pop && !item_take) begin
            count_ff <= count_ff - pnm_pkg::COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         result_ff[wr_ptr_ff] <= new_result;
      end
   end

endmodule

### rtl/pnm_header_parser_core.sv
// Channel    | Ports                                            | Transaction when
// -----------+--------------------------------------------------+------------------------
// request    | push, full, req_data_byte, req_input_ended,      | push && !full
//            | req_start_new                                    |
// response   | empty, pop, rsp_status, rsp_image_width,         | pop && !empty
//            | rsp_image_height, rsp_max_value                  |
//
// One byte per cycle sustained while responses are popped; each request gives exactly one response.
// A taken request is registered in the classifier queue, then the parse state update
// writes its result into the result queue, which drives the response ports.
// Both queues are two entries deep; full rises only while the classifier queue is full.
// Synchronous reset empties both queues and returns the parser to its start state.
module pnm_header_parser_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_input_ended,
   input  logic                         req_start_new,
   output logic                         empty,
   input  logic                         pop,
   output logic [2:0]                   rsp_status,
   output logic [pnm_pkg::OUT_BITS-1:0] rsp_image_width,
   output logic [pnm_pkg::OUT_BITS-1:0] rsp_image_height,
   output logic [pnm_pkg::OUT_BITS-1:0] rsp_max_value
);

   pnm_pkg::item_type front_item;
   pnm_pkg::item_type queued_item;
   pnm_pkg::result_type result;
   logic queue_empty;
   logic back_take;

   pnm_front u_front (
      .data_byte   (req_data_byte),
      .input_ended (req_input_ended),
      .start_new   (req_start_new),
      .item        (front_item)
   );

   pnm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && !full),
      .wr_item (front_item),
      .full    (full),
      .rd_en   (back_take),
      .rd_item (queued_item),
      .empty   (queue_empty)
   );

   pnm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!queue_empty),
      .item       (queued_item),
      .item_take  (back_take),
      .out_pop    (pop),
      .out_empty  (empty),
      .out_result (result)
   );

   assign rsp_status = result.status;
   assign rsp_image_width = result.image_width;
   assign rsp_image_height = result.image_height;
   assign rsp_max_value = result.max_value;

endmodule

### rtl/pnm_checker.sv
module pnm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         push,
   input logic                         full,
   input logic                         empty,
   input logic                         pop,
   input logic [2:0]                   rsp_status,
   input logic [pnm_pkg::OUT_BITS-1:0] rsp_image_width
);

   // Reset leaves both sides with nothing waiting.
   assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // Every waiting response carries a defined status code.
   assert property (@(posedge clock) disable iff (reset)
                    !empty |-> (rsp_status <= pnm_pkg::STATUS_EARLY_END))
      else $error("undefined status on response");

   // A response that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
                    (!empty && !pop) |=> (!empty && $stable(rsp_image_width)))
      else $error("response dropped or changed while stalled");

   // With nothing waiting at the output, a taken request shows up once it has passed the classifier queue.
   assert property (@(posedge clock) disable iff (reset)
                    (push && !full && empty) |=> ##1 !empty)
      else $error("response missing two cycles after request");

endmodule

bind pnm_header_parser_core pnm_checker u_pnm_checker (
   .clock           (clock),
   .reset           (reset),
   .push            (push),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_status      (rsp_status),
   .rsp_image_width (rsp_image_width)
);

### dv/pnm_header_parser_core_test.sv
module pnm_header_parser_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pnm_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int FEED_ITEMS = 1900;
   localparam int CALM_TAIL = 150;

   typedef struct {
      logic [7:0] data;
      logic       ended;
      logic       fresh;
      bit         hold;
   } header_byte_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [7:0]          req_data_byte = 8'd0;
   logic                req_input_ended = 1'b0;
   logic                req_start_new = 1'b0;
   logic                empty;
   logic                pop = 1'b0;
   logic [2:0]          rsp_status;
   logic [OUT_BITS-1:0] rsp_image_width;
   logic [OUT_BITS-1:0] rsp_image_height;
   logic [OUT_BITS-1:0] rsp_max_value;

   pnm_header_parser_core DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_input_ended  (req_input_ended),
      .req_start_new    (req_start_new),
      .empty            (empty),
      .pop              (pop),
      .rsp_status       (rsp_status),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_max_value    (rsp_max_value)
   );

   always #4 clock = ~clock;

   header_byte_t header_feed[$];
   logic [7:0]   draft[$];
   result_type   parse_results[$];
   bit           tail_calm = 1'b0;
   int           mismatches = 0;
   int           bytes_sent = 0;
   int           results_checked = 0;
   int           verdict_hits[8];

   // Parser state as the block should hold it.
   phase_type              cur_phase;
   logic                   in_cmt;
   int unsigned            line_len;
   class_type              first_cls;
   step_type               num_step;
   logic [VALUE_BITS-1:0]  width_acc;
   logic [VALUE_BITS-1:0]  height_acc;
   logic [VALUE_BITS-1:0]  maxval_acc;
   logic [2:0]             verdict;

   function automatic logic [VALUE_BITS-1:0] scaled_digit(logic [VALUE_BITS-1:0] acc,
                                                          logic [3:0] d);
      longint unsigned v;
      longint unsigned cap;
      cap = (64'd1 << VALUE_BITS) - 1;
      v = acc * 10 + d;
      if (v > cap) begin
         v = cap;
      end
      return v[VALUE_BITS-1:0];
   endfunction

   function automatic bit is_gap_char(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB || c == CHAR_FEED ||
             c == CHAR_RETURN;
   endfunction

   function automatic void clear_line();
      in_cmt = 1'b0;
      line_len = 0;
      first_cls = CLASS_NONE;
      num_step = STEP_FIRST;
   endfunction

   function automatic void clear_parse();
      cur_phase = PHASE_MAGIC;
      clear_line();
      width_acc = '0;
      height_acc = '0;
      maxval_acc = '0;
      verdict = STATUS_PARSING;
   endfunction

   function automatic result_type parse_byte(header_byte_t it);
      logic [7:0] c;
      logic       dig;
      logic [3:0] d;
      result_type r;
      c = it.data;
      dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = dig ? 4'(c - CHAR_ZERO) : 4'd0;
      if (it.fresh) begin
         clear_parse();
      end
      if (verdict == STATUS_PARSING) begin
         if (it.ended) begin
            verdict = STATUS_EARLY_END;
         end else if (c == CHAR_NEWLINE) begin
            // A line is judged only when its newline arrives; empty lines are skipped.
            if (first_cls != CLASS_NONE) begin
               case (cur_phase)
                  PHASE_MAGIC: begin
                     if (first_cls == CLASS_P) cur_phase = PHASE_SIZE;
                     else verdict = STATUS_BAD_MAGIC;
                  end
                  PHASE_SIZE: begin
                     if (first_cls == CLASS_DIGIT &&
                         (num_step == STEP_SECOND || num_step == STEP_TAIL)) begin
                        cur_phase = PHASE_MAX;
                     end else begin
                        verdict = STATUS_BAD_SIZE;
                     end
                  end
                  PHASE_MAX: begin
                     if (first_cls == CLASS_DIGIT) begin
                        cur_phase = PHASE_DONE;
                        verdict = STATUS_DONE;
                     end else begin
                        verdict = STATUS_BAD_MAX;
                     end
                  end
                  default: ;
               endcase
            end
            clear_line();
         end else if (c == CHAR_HASH) begin
            in_cmt = 1'b1;
         end else if (!in_cmt) begin
            if (line_len == 0) begin
               if (c == CHAR_P) first_cls = CLASS_P;
               else if (dig) first_cls = CLASS_DIGIT;
               else first_cls = CLASS_OTHER;
               num_step = STEP_FIRST;
               if (dig && cur_phase == PHASE_SIZE) begin
                  width_acc = '0;
                  height_acc = '0;
               end
               if (dig && cur_phase == PHASE_MAX) begin
                  maxval_acc = '0;
               end
            end
            if (first_cls == CLASS_DIGIT && cur_phase == PHASE_SIZE) begin
               case (num_step)
                  STEP_FIRST: begin
                     if (dig) width_acc = scaled_digit(width_acc, d);
                     else if (is_gap_char(c)) num_step = STEP_GAP;
                     else num_step = STEP_FAIL;
                  end
                  STEP_GAP: begin
                     if (dig) begin
                        height_acc = scaled_digit(height_acc, d);
                        num_step = STEP_SECOND;
                     end else if (!is_gap_char(c)) begin
                        num_step = STEP_FAIL;
                     end
                  end
                  STEP_SECOND: begin
                     if (dig) height_acc = scaled_digit(height_acc, d);
                     else num_step = STEP_TAIL;
                  end
                  default: ;
               endcase
            end else if (first_cls == CLASS_DIGIT && cur_phase == PHASE_MAX &&
                         num_step == STEP_FIRST) begin
               if (dig) maxval_acc = scaled_digit(maxval_acc, d);
               else num_step = STEP_TAIL;
            end
            line_len++;
            if (line_len >= LINE_LIMIT) begin
               verdict = STATUS_TOO_LONG;
            end
         end
         if (verdict != STATUS_PARSING) begin
            verdict_hits[verdict]++;
         end
      end
      r.status = verdict;
      r.image_width = width_acc;
      r.image_height = height_acc;
      r.max_value = maxval_acc;
      return r;
   endfunction

   // Stimulus building: bytes collect in the draft, then move to the feed.
   task automatic add_byte(logic [7:0] b, bit fresh, bit hold);
      header_feed.push_back('{data: b, ended: 1'b0, fresh: fresh, hold: hold});
   endtask

   task automatic add_end(bit fresh);
      header_feed.push_back('{data: 8'($urandom_range(0, 255)), ended: 1'b1, fresh: fresh,
                              hold: 1'b0});
   endtask

   task automatic flush_draft(bit hold);
      for (int i = 0; i < draft.size(); i++) begin
         add_byte(draft[i], i == 0 || $urandom_range(0, 299) == 0, i == 0 && hold);
      end
      draft.delete();
   endtask

   task automatic put(logic [7:0] b);
      draft.push_back(b);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         put(s[i]);
      end
   endtask

   function automatic logic [7:0] junk_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == CHAR_NEWLINE || b == CHAR_HASH) begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   // A kept character that is neither a digit, a blank nor 'P'.
   function automatic logic [7:0] odd_char();
      logic [7:0] b;
      b = junk_char();
      while ((b >= CHAR_ZERO && b <= CHAR_NINE) || is_gap_char(b) || b == CHAR_P) begin
         b = junk_char();
      end
      return b;
   endfunction

   task automatic put_junk(int n);
      repeat (n) put(junk_char());
   endtask

   task automatic put_blanks(int n);
      repeat (n) begin
         case ($urandom_range(0, 4))
            0: put(CHAR_SPACE);
            1: put(CHAR_TAB);
            2: put(CHAR_VTAB);
            3: put(CHAR_FEED);
            default: put(CHAR_RETURN);
         endcase
      end
   endtask

   task automatic put_comment();
      put(CHAR_HASH);
      repeat ($urandom_range(0, 6)) begin
         logic [7:0] b;
         b = 8'($urandom_range(0, 255));
         put(b == CHAR_NEWLINE ? CHAR_HASH : b);
      end
   endtask

   task automatic put_number();
      case ($urandom_range(0, 19))
         0, 1: put_text("65535");
         2, 3: put_text("65536");
         4: repeat ($urandom_range(6, 8)) put(8'(CHAR_ZERO + $urandom_range(0, 9)));
         default: repeat ($urandom_range(1, 4)) put(8'(CHAR_ZERO + $urandom_range(0, 9)));
      endcase
   endtask

   task automatic put_tail();
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            put_blanks($urandom_range(1, 2));
            put_junk($urandom_range(1, 3));
         end
         2: put_junk($urandom_range(1, 3));
         default: put_comment();
      endcase
   endtask

   // Lines with no kept character: bare newlines and comment-only lines.
   task automatic put_filler();
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 1) == 0) put_comment();
            put(CHAR_NEWLINE);
         end
      end
   endtask

   task automatic put_header();
      int flaw;
      int size_flaw;
      int n;
      flaw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      size_flaw = (flaw == 2) ? $urandom_range(0, 4) : -1;

      if ($urandom_range(0, 14) == 0) begin
         repeat ($urandom_range(1, 24)) begin
            put(($urandom_range(0, 3) == 0) ? CHAR_NEWLINE : 8'($urandom_range(0, 255)));
         end
         flush_draft(1'b0);
         if ($urandom_range(0, 1) == 0) add_end(1'b0);
         return;
      end

      put_filler();
      put(flaw == 1 ? odd_char() : CHAR_P);
      // Now and then the magic line runs to either side of the length limit.
      if ($urandom_range(0, 39) == 0) put_junk(LINE_LIMIT - 4 + $urandom_range(0, 5));
      else put_junk($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) put_comment();
      put(CHAR_NEWLINE);

      put_filler();
      if (size_flaw == 0) put_blanks(1);
      if (size_flaw == 1) put(odd_char());
      put_number();
      if (size_flaw == 2) put(odd_char());
      put_blanks($urandom_range(1, 3));
      if (size_flaw == 3) put($urandom_range(0, 1) ? 8'h2B : 8'h2D);
      if (size_flaw != 4) begin
         put_number();
         put_tail();
      end
      put(CHAR_NEWLINE);

      put_filler();
      if (flaw == 3) put(odd_char());
      put_number();
      put_tail();
      put(CHAR_NEWLINE);

      case ($urandom_range(0, 9))
         0: begin
            n = $urandom_range(1, draft.size());
            while (draft.size() > n) draft.delete(draft.size() - 1);
            flush_draft($urandom_range(0, 29) == 0);
            add_end(1'b0);
         end
         1: begin
            put_junk($urandom_range(1, 3));
            flush_draft($urandom_range(0, 29) == 0);
            add_end(1'b0);
         end
         2: begin
            n = $urandom_range(1, draft.size());
            while (draft.size() > n) draft.delete(draft.size() - 1);
            flush_draft($urandom_range(0, 29) == 0);
         end
         default: flush_draft($urandom_range(0, 29) == 0);
      endcase
   endtask

   function automatic int pick_odds();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         2: return 8;
         default: return 24;
      endcase
   endfunction

   always @(posedge clock) begin : driver
      header_byte_t next_item;
      logic         push_next;
      int           idle_left;
      int           idle_odds;
      int           window;
      if (reset) begin
         push <= 1'b0;
         req_data_byte <= 8'd0;
         req_input_ended <= 1'b0;
         req_start_new <= 1'b0;
         clear_parse();
         idle_left = 0;
         idle_odds = 0;
         window = 0;
      end else begin
         if (push && !full) begin
            next_item.data = req_data_byte;
            next_item.ended = req_input_ended;
            next_item.fresh = req_start_new;
            next_item.hold = 1'b0;
            parse_results.push_back(parse_byte(next_item));
            bytes_sent++;
         end
         window++;
         if (window % 256 == 0) idle_odds = pick_odds();
         tail_calm = header_feed.size() < CALM_TAIL;
         push_next = push;
         if (!(push && full)) begin
            push_next = 1'b0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (!tail_calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
               idle_left = $urandom_range(0, 10);
            end else if (header_feed.size() != 0 &&
                         !(header_feed[0].hold && parse_results.size() != 0)) begin
               // A held item waits until every earlier transaction has its result.
               next_item = header_feed.pop_front();
               req_data_byte <= next_item.data;
               req_input_ended <= next_item.ended;
               req_start_new <= next_item.fresh;
               push_next = 1'b1;
            end
         end
         push <= push_next;
      end
   end

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("result %0d: %s expected %0d, got %0d", results_checked, field, want,
                     got);
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      int         stall_left;
      int         stall_odds;
      int         window;
      if (reset) begin
         pop <= 1'b0;
         stall_left = 0;
         stall_odds = 0;
         window = 0;
      end else begin
         if (pop && !empty) begin
            if (parse_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result with status %0d arrived with none expected", rsp_status);
               end
            end else begin
               want = parse_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("image_width", want.image_width, rsp_image_width);
               check_field("image_height", want.image_height, rsp_image_height);
               check_field("max_value", want.max_value, rsp_max_value);
            end
            results_checked++;
         end
         window++;
         if (window % 256 == 128) stall_odds = pick_odds();
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!tail_calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(0, 10);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding", quiet_cycles,
                     parse_results.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      // Directed headers: extreme bytes in the magic line and a saturated width.
      put(CHAR_P);
      put(8'h00);
      put(8'hFF);
      put(CHAR_NEWLINE);
      put_text("70000 9\n1\n");
      flush_draft(1'b0);
      // Once finished, bytes and end marks change nothing.
      add_byte("x", 1'b0, 1'b0);
      add_end(1'b0);
      // An end mark right after a restart ends the header early.
      add_end(1'b1);
      // A bad magic line, sent only after everything earlier has drained.
      put_text("-\n");
      flush_draft(1'b1);
      // A sign before the height is not accepted.
      put_text("P\n1 -2\n");
      flush_draft(1'b0);

      while (header_feed.size() < FEED_ITEMS) put_header();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (header_feed.size() != 0 || push || parse_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (parse_results.size() != 0) begin
         $display("%0d expected results never arrived", parse_results.size());
         mismatches += parse_results.size();
      end

      $display("%0d bytes and end marks sent, %0d results checked, %0d mismatches",
               bytes_sent, results_checked, mismatches);
      $display("headers: %0d complete, %0d bad magic, %0d bad size, %0d bad maxval, %0d %s",
               verdict_hits[STATUS_DONE], verdict_hits[STATUS_BAD_MAGIC],
               verdict_hits[STATUS_BAD_SIZE], verdict_hits[STATUS_BAD_MAX],
               verdict_hits[STATUS_TOO_LONG],
               $sformatf("overlong, %0d cut short", verdict_hits[STATUS_EARLY_END]));
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/pnm_pkg.sv
rtl/pnm_front.sv
rtl/pnm_queue.sv
rtl/pnm_back.sv
rtl/pnm_header_parser_core.sv
rtl/pnm_checker.sv
dv/pnm_header_parser_core_test.sv
